[design/fcc_pkg.sv]
// Package with the types, codes and helper functions of the framed CRC-8 checker.
`default_nettype none

package fcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_DIGIT_BASE = 8'd48;
    localparam logic [7:0] CH_UPPER_BASE = 8'd55;
    localparam logic [7:0] CH_LOWER_BASE = 8'd87;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_START    = 3'd1,
        ST_NO_END      = 3'd2,
        ST_BAD_LENGTH  = 3'd3,
        ST_CRC_MISMATCH = 3'd4
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] computed_crc;
        logic [7:0] received_crc;
        logic [7:0] payload_length;
    } t_result;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Returns {bad, nibble}; a character that is not hex decodes as zero with bad set.
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [7:0] v;
        logic       bad;
        v   = 8'd0;
        bad = 1'b0;
        if (ch >= 8'd48 && ch <= 8'd57) begin
            v = ch - CH_DIGIT_BASE;
        end else if (ch >= 8'd65 && ch <= 8'd70) begin
            v = ch - CH_UPPER_BASE;
        end else if (ch >= 8'd97 && ch <= 8'd102) begin
            v = ch - CH_LOWER_BASE;
        end else begin
            bad = 1'b1;
        end
        return {bad, v[3:0]};
    endfunction

endpackage

`default_nettype wire

[design/fcc_if.sv]
// Channel interfaces of the framed CRC-8 checker: input bytes, results and configuration.
`default_nettype none

interface fcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface fcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] computed_crc;
    logic [7:0] received_crc;
    logic [7:0] payload_length;

    modport source (output valid, output status, output computed_crc, output received_crc,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input computed_crc, input received_crc,
                    input payload_length, output ready);
endinterface

interface fcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] crc_start;

    modport source (output valid, output crc_start, input ready);
    modport sink   (input valid, input crc_start, output ready);
endinterface

`default_nettype wire

[design/fcc_frame_core.sv]
// Frame state, CRC update, trailer window and end-of-frame checks of the checker.
`default_nettype none

module fcc_frame_core #(
    parameter int unsigned MAX_FRAME_LEN = 255
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_frame_byte,
    input  wire logic           i_last_byte,
    input  wire logic [7:0]     i_crc_start,
    output fcc_pkg::t_result    o_result
);

    localparam int CW = $clog2(MAX_FRAME_LEN + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    logic [7:0]    r_crc;
    logic [7:0]    r_win [3];
    logic [CW-1:0] r_count;
    logic          r_start_seen;
    logic          r_overflow;

    logic          first;
    logic          bad_len;
    logic          bad_hex;
    logic [4:0]    hi_dec;
    logic [4:0]    lo_dec;
    logic [7:0]    crc_tail;
    logic [7:0]    comp;
    logic [7:0]    recv;
    logic [PW-1:0] plen_full;
    logic [7:0]    plen;

    assign first = (r_count == '0) && !r_overflow;

    always_comb begin
        bad_len   = r_overflow || (r_count >= CW'(MAX_FRAME_LEN)) || (r_count < CW'(3));
        hi_dec    = fcc_pkg::hex_nibble(r_win[1]);
        lo_dec    = fcc_pkg::hex_nibble(r_win[2]);
        bad_hex   = hi_dec[4] || lo_dec[4];
        crc_tail  = fcc_pkg::crc8_update(r_crc, r_win[0]);
        plen_full = PW'(r_count) - PW'(3);
        plen      = (plen_full > PW'(255)) ? 8'd255 : plen_full[7:0];
        comp      = 8'd0;
        recv      = 8'd0;
        if (!bad_len) begin
            comp = (r_count >= CW'(4)) ? crc_tail : r_crc;
            recv = {hi_dec[3:0], lo_dec[3:0]};
        end
    end

    always_comb begin
        o_result.computed_crc   = comp;
        o_result.received_crc   = recv;
        o_result.payload_length = bad_len ? 8'd0 : plen;
        if (!(first ? (i_frame_byte == fcc_pkg::CH_OPEN) : r_start_seen)) begin
            o_result.status = fcc_pkg::ST_NO_START;
        end else if (i_frame_byte != fcc_pkg::CH_CLOSE) begin
            o_result.status = fcc_pkg::ST_NO_END;
        end else if (bad_len) begin
            o_result.status = fcc_pkg::ST_BAD_LENGTH;
        end else if (bad_hex || (comp != recv)) begin
            o_result.status = fcc_pkg::ST_CRC_MISMATCH;
        end else begin
            o_result.status = fcc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= 8'd0;
            r_win[0]     <= 8'd0;
            r_win[1]     <= 8'd0;
            r_win[2]     <= 8'd0;
            r_count      <= '0;
            r_start_seen <= 1'b0;
            r_overflow   <= 1'b0;
        end else if (i_step) begin
            if (i_last_byte) begin
                r_crc        <= i_crc_start;
                r_win[0]     <= 8'd0;
                r_win[1]     <= 8'd0;
                r_win[2]     <= 8'd0;
                r_count      <= '0;
                r_start_seen <= 1'b0;
                r_overflow   <= 1'b0;
            end else begin
                if (first) begin
                    r_crc        <= i_crc_start;
                    r_start_seen <= (i_frame_byte == fcc_pkg::CH_OPEN);
                end else begin
                    if (r_count >= CW'(4)) begin
                        r_crc <= crc_tail;
                    end
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= i_frame_byte;
                end
                if (r_count < CW'(MAX_FRAME_LEN)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/framed_packet_crc8_checker_unit.sv]
// Top level of the framed packet CRC-8 checker.
// The block checks frames of the form '(' payload, two hex CRC characters, ')'.
// Bytes enter on i_in, one item per byte, with last_byte set on the final byte.
// Each frame gives one item on o_out when its final byte has been processed:
// a status code, the computed and received CRC and the payload length.
// i_cfg writes the CRC start value, which is taken at the first byte of a frame.
// The input channel takes one byte per cycle unless a final byte is waiting; an item
// is registered when it is accepted and is processed from that register, and the
// result of a final byte goes to the result register. The result register holds a finished
// result while o_out is stalled; bytes that are not final keep flowing meanwhile,
// and only a final byte waits for the result register to free up.
// Reset clears all frame state, the pending items and the CRC start value to zero.
`default_nettype none

module framed_packet_crc8_checker_unit #(
    parameter int unsigned MAX_FRAME_LEN = 255
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fcc_in_if.sink     i_in,
    fcc_cfg_if.sink    i_cfg,
    fcc_out_if.source  o_out
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    fcc_pkg::t_result r_out;
    logic [7:0]       r_crc_start;

    logic             out_free;
    logic             proc;
    fcc_pkg::t_result core_result;

    assign out_free    = !r_out_valid || o_out.ready;
    assign proc        = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready  = !r_in_valid || proc;
    assign i_cfg.ready = 1'b1;

    fcc_frame_core #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (proc),
        .i_frame_byte(r_in_byte),
        .i_last_byte (r_in_last),
        .i_crc_start (r_crc_start),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_start <= 8'd0;
        end else if (i_cfg.valid) begin
            r_crc_start <= i_cfg.crc_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.frame_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.computed_crc   = r_out.computed_crc;
    assign o_out.received_crc   = r_out.received_crc;
    assign o_out.payload_length = r_out.payload_length;

endmodule

`default_nettype wire

[dv/tb_framed_packet_crc8_checker_unit.sv]
// Self-checking testbench for the framed packet CRC-8 checker, with an in-bench frame predictor.
`timescale 1ns / 1ps

module tb_framed_packet_crc8_checker_unit;

    localparam int FRAME_MAX = 255;

    typedef logic [7:0] t_bytes [$];

    logic i_clk;
    logic i_rst_n;

    fcc_in_if  in_if ();
    fcc_out_if out_if ();
    fcc_cfg_if cfg_if ();

    framed_packet_crc8_checker_unit #(
        .MAX_FRAME_LEN(FRAME_MAX)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    logic [7:0] crc_seed;
    logic [7:0] run_crc;
    logic [7:0] tail [3];
    logic [8:0] frame_count;
    logic       open_seen;
    logic       overflow;

    fcc_pkg::t_result expected_q [$];
    t_bytes  frame_buf;
    int      fail_count;
    int      bytes_sent;
    bit      pace_on;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        repeat (8) c = c[7] ? ((c << 1) ^ fcc_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - fcc_pkg::CH_DIGIT_BASE)};
        if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - fcc_pkg::CH_UPPER_BASE)};
        if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - fcc_pkg::CH_LOWER_BASE)};
        return 5'b10000;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return fcc_pkg::CH_DIGIT_BASE + n;
        return ($urandom_range(1) ? fcc_pkg::CH_UPPER_BASE : fcc_pkg::CH_LOWER_BASE) + n;
    endfunction

    task automatic clear_frame_state();
        run_crc = crc_seed;
        tail[0] = 8'h00;
        tail[1] = 8'h00;
        tail[2] = 8'h00;
        frame_count = '0;
        open_seen = 1'b0;
        overflow = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic             first;
        logic             bad_len;
        logic [4:0]       hi;
        logic [4:0]       lo;
        logic [8:0]       total;
        fcc_pkg::t_result r;
        first = (frame_count == 0) && !overflow;
        if (first) begin
            run_crc = crc_seed;
            open_seen = (b == fcc_pkg::CH_OPEN);
        end
        if (!last) begin
            if (!first) begin
                if (frame_count >= 4) run_crc = crc8_byte(run_crc, tail[0]);
                tail[0] = tail[1];
                tail[1] = tail[2];
                tail[2] = b;
            end
            if (frame_count < FRAME_MAX) begin
                frame_count++;
            end else begin
                overflow = 1'b1;
            end
        end else begin
            total = frame_count + 9'd1;
            bad_len = overflow || frame_count >= FRAME_MAX || total < 4;
            r = '0;
            hi = '0;
            lo = '0;
            if (!bad_len) begin
                r.computed_crc = (total >= 5) ? crc8_byte(run_crc, tail[0]) : run_crc;
                hi = hex_value(tail[1]);
                lo = hex_value(tail[2]);
                r.received_crc = {hi[3:0], lo[3:0]};
                r.payload_length = 8'(total - 9'd4);
            end
            if (!open_seen) begin
                r.status = fcc_pkg::ST_NO_START;
            end else if (b != fcc_pkg::CH_CLOSE) begin
                r.status = fcc_pkg::ST_NO_END;
            end else if (bad_len) begin
                r.status = fcc_pkg::ST_BAD_LENGTH;
            end else if (hi[4] || lo[4] || r.computed_crc != r.received_crc) begin
                r.status = fcc_pkg::ST_CRC_MISMATCH;
            end else begin
                r.status = fcc_pkg::ST_OK;
            end
            expected_q.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        fcc_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", int'(out_if.status), 0);
            end else begin
                want = expected_q.pop_front();
                if (out_if.status !== want.status)
                    report_mismatch("status", int'(out_if.status), int'(want.status));
                if (out_if.computed_crc !== want.computed_crc)
                    report_mismatch("computed_crc", int'(out_if.computed_crc),
                                    int'(want.computed_crc));
                if (out_if.received_crc !== want.received_crc)
                    report_mismatch("received_crc", int'(out_if.received_crc),
                                    int'(want.received_crc));
                if (out_if.payload_length !== want.payload_length)
                    report_mismatch("payload_length", int'(out_if.payload_length),
                                    int'(want.payload_length));
            end
        end
        out_if.ready <= !pace_on || ($urandom_range(99) >= 37);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (pace_on && $urandom_range(99) < 37) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.frame_byte <= b;
        in_if.last_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic build_good(input int plen);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc_seed;
        frame_buf.delete();
        frame_buf.push_back(fcc_pkg::CH_OPEN);
        repeat (plen) begin
            b = 8'($urandom_range(255));
            frame_buf.push_back(b);
            crc = crc8_byte(crc, b);
        end
        frame_buf.push_back(hex_char(crc[7:4]));
        frame_buf.push_back(hex_char(crc[3:0]));
        frame_buf.push_back(fcc_pkg::CH_CLOSE);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_crc_start(input logic [7:0] v);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.crc_start <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        crc_seed = v;
        run_crc = v;
    endtask

    task automatic test_directed();
        frame_buf = '{fcc_pkg::CH_OPEN, "0", "0", fcc_pkg::CH_CLOSE};
        send_frame();
        build_good(1);
        frame_buf[1] = 8'hFF;
        frame_buf[2] = "f";
        frame_buf[3] = "3";
        send_frame();
        frame_buf = '{fcc_pkg::CH_CLOSE};
        send_frame();
        frame_buf = '{fcc_pkg::CH_OPEN};
        send_frame();
        frame_buf = '{fcc_pkg::CH_OPEN, fcc_pkg::CH_CLOSE};
        send_frame();
        frame_buf = '{fcc_pkg::CH_OPEN, "0", fcc_pkg::CH_CLOSE};
        send_frame();
        frame_buf = '{fcc_pkg::CH_OPEN, "G", "0", fcc_pkg::CH_CLOSE};
        send_frame();
    endtask

    task automatic test_crc_start();
        write_crc_start(8'hFF);
        build_good(3);
        send_frame();
        build_good(2);
        frame_buf[frame_buf.size() - 2] = hex_char(4'($urandom_range(15)));
        send_frame();
        write_crc_start(8'h00);
        build_good(3);
        send_frame();
        write_crc_start(8'hA5);
        build_good(0);
        send_frame();
    endtask

    task automatic test_length_limits();
        pace_on = 1'b0;
        build_good(FRAME_MAX - 4);
        send_frame();
        build_good(FRAME_MAX - 3);
        send_frame();
        build_good(FRAME_MAX + 41);
        send_frame();
        drain();
        pace_on = 1'b1;
    endtask

    task automatic test_random();
        int kind;
        int frames;
        int n;
        frames = 0;
        while (bytes_sent < 1450) begin
            if (frames % 12 == 11) begin
                kind = $urandom_range(3);
                write_crc_start(kind == 0 ? 8'h00 : kind == 1 ? 8'hFF : 8'($urandom));
            end
            build_good($urandom_range(9) == 0 ? $urandom_range(60) : $urandom_range(12));
            n = frame_buf.size();
            kind = $urandom_range(99);
            if (kind < 65) begin
            end else if (kind < 72) begin
                frame_buf[n - 2] = hex_char(4'($urandom_range(15)));
            end else if (kind < 78) begin
                frame_buf[n - 2 - $urandom_range(1)] = 8'($urandom_range(255));
            end else if (kind < 83) begin
                frame_buf[0] = 8'($urandom_range(255));
            end else if (kind < 88) begin
                frame_buf[n - 1] = 8'($urandom_range(255));
            end else if (kind < 94) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(2))
                        0: frame_buf.push_back(fcc_pkg::CH_OPEN);
                        1: frame_buf.push_back(fcc_pkg::CH_CLOSE);
                        default: frame_buf.push_back(8'($urandom_range(255)));
                    endcase
                end
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom_range(255)));
            end
            send_frame();
            frames++;
        end
    endtask

    initial begin
        in_if.valid <= 1'b0;
        in_if.frame_byte <= 8'h00;
        in_if.last_byte <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.crc_start <= 8'h00;
        i_rst_n <= 1'b0;
        pace_on = 1'b1;
        fail_count = 0;
        bytes_sent = 0;
        crc_seed = 8'h00;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_crc_start();
        test_length_limits();
        test_random();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
design/fcc_pkg.sv
design/fcc_if.sv
design/fcc_frame_core.sv
design/framed_packet_crc8_checker_unit.sv
dv/tb_framed_packet_crc8_checker_unit.sv
